FILE: rtl/ftqg_pkg.sv
// ----------------------------------------------------------------------------
// ftqg_pkg
// Shared types and constants of the frame time quality governor: field
// widths, register indexes, reset values, tier codes and the transfer structs.
// ----------------------------------------------------------------------------
package ftqg_pkg;

    // Field widths
    localparam int TIME_W     = 20;
    localparam int WIN_W      = 16;
    localparam int HOLD_W     = 16;
    localparam int TIER_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Average update: new = old + (sample - old) * 0.1, coefficient in Q0.16
    localparam int COEF_NEW     = 6554;
    localparam int COEF_SHIFT   = 16;
    localparam int AVG_START_US = 16670;

    // Quality tiers
    typedef logic [TIER_W-1:0] t_tier;
    localparam t_tier TIER_HIGH = 2'd0;
    localparam t_tier TIER_MID  = 2'd1;
    localparam t_tier TIER_LOW  = 2'd2;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEGRADE_THR  = 3'd0,
        REG_RECOVER_THR  = 3'd1,
        REG_DEGRADE_WIN  = 3'd2,
        REG_RECOVER_WIN  = 3'd3,
        REG_COOLDOWN     = 3'd4,
        REG_STARTUP_TIER = 3'd5
    } t_reg_idx;

    // Register reset values
    localparam logic [TIME_W-1:0] RST_DEGRADE_THR  = 20'd20000;
    localparam logic [TIME_W-1:0] RST_RECOVER_THR  = 20'd15500;
    localparam logic [WIN_W-1:0]  RST_DEGRADE_WIN  = 16'd120;
    localparam logic [WIN_W-1:0]  RST_RECOVER_WIN  = 16'd300;
    localparam logic [HOLD_W-1:0] RST_COOLDOWN     = 16'd120;
    localparam t_tier             RST_STARTUP_TIER = TIER_HIGH;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [TIME_W-1:0] degrade_thr;
        logic [TIME_W-1:0] recover_thr;
        logic [WIN_W-1:0]  degrade_win;
        logic [WIN_W-1:0]  recover_win;
        logic [HOLD_W-1:0] cooldown;
        t_tier             startup_tier;
    } t_cfg;

    // One result transaction
    typedef struct packed {
        t_tier             active_tier;
        logic              tier_changed;
        logic              tier_lowered;
        logic [TIME_W-1:0] smoothed_time_us;
    } t_result;

endpackage

FILE: rtl/ftqg_if.sv
// ----------------------------------------------------------------------------
// ftqg channel interfaces
// Valid/ready channels for frame times, results and register writes.
// ----------------------------------------------------------------------------
interface ftqg_frame_if;
    logic                          valid;
    logic                          ready;
    logic [ftqg_pkg::TIME_W-1:0]   frame_time_us;

    modport source (output valid, output frame_time_us, input ready);
    modport sink   (input valid, input frame_time_us, output ready);
endinterface

interface ftqg_result_if;
    logic                          valid;
    logic                          ready;
    ftqg_pkg::t_tier               active_tier;
    logic                          tier_changed;
    logic                          tier_lowered;
    logic [ftqg_pkg::TIME_W-1:0]   smoothed_time_us;

    modport source (output valid, output active_tier, output tier_changed,
                    output tier_lowered, output smoothed_time_us, input ready);
    modport sink   (input valid, input active_tier, input tier_changed,
                    input tier_lowered, input smoothed_time_us, output ready);
endinterface

interface ftqg_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ftqg_pkg::CFG_IDX_W-1:0]   index;
    logic [ftqg_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/ftqg_cfg_regs.sv
// ----------------------------------------------------------------------------
// ftqg_cfg_regs
// Register file for thresholds, windows, cooldown and startup tier.
// ----------------------------------------------------------------------------
module ftqg_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ftqg_cfg_if.sink        i_cfg,
    output ftqg_pkg::t_cfg  o_cfg
);

    ftqg_pkg::t_cfg r_cfg;

    // Writes are always accepted
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.degrade_thr  <= ftqg_pkg::RST_DEGRADE_THR;
            r_cfg.recover_thr  <= ftqg_pkg::RST_RECOVER_THR;
            r_cfg.degrade_win  <= ftqg_pkg::RST_DEGRADE_WIN;
            r_cfg.recover_win  <= ftqg_pkg::RST_RECOVER_WIN;
            r_cfg.cooldown     <= ftqg_pkg::RST_COOLDOWN;
            r_cfg.startup_tier <= ftqg_pkg::RST_STARTUP_TIER;
        end else if (i_cfg.valid) begin
            unique case (ftqg_pkg::t_reg_idx'(i_cfg.index))
                ftqg_pkg::REG_DEGRADE_THR: begin
                    r_cfg.degrade_thr <= i_cfg.data[ftqg_pkg::TIME_W-1:0];
                end
                ftqg_pkg::REG_RECOVER_THR: begin
                    r_cfg.recover_thr <= i_cfg.data[ftqg_pkg::TIME_W-1:0];
                end
                ftqg_pkg::REG_DEGRADE_WIN: begin
                    r_cfg.degrade_win <= i_cfg.data[ftqg_pkg::WIN_W-1:0];
                end
                ftqg_pkg::REG_RECOVER_WIN: begin
                    r_cfg.recover_win <= i_cfg.data[ftqg_pkg::WIN_W-1:0];
                end
                ftqg_pkg::REG_COOLDOWN: begin
                    r_cfg.cooldown <= i_cfg.data[ftqg_pkg::HOLD_W-1:0];
                end
                ftqg_pkg::REG_STARTUP_TIER: begin
                    r_cfg.startup_tier <= i_cfg.data[ftqg_pkg::TIER_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: rtl/ftqg_avg_update.sv
// ----------------------------------------------------------------------------
// ftqg_avg_update
// Exponential average step: 0.9 old + 0.1 new in Q0.16, truncated.
// ----------------------------------------------------------------------------
module ftqg_avg_update #(
    parameter int FRAC_BITS = 8
) (
    input  logic [ftqg_pkg::TIME_W+FRAC_BITS-1:0] i_avg,
    input  logic [ftqg_pkg::TIME_W-1:0]           i_ft,
    output logic [ftqg_pkg::TIME_W+FRAC_BITS-1:0] o_avg
);

    localparam int AW  = ftqg_pkg::TIME_W + FRAC_BITS;
    localparam int CW  = 14;
    localparam int SH  = ftqg_pkg::COEF_SHIFT;
    localparam int SW  = AW + SH + 1;
    localparam int PW  = AW + 1 + CW;
    localparam logic signed [CW-1:0] COEF = CW'(ftqg_pkg::COEF_NEW);

    logic [AW-1:0]        w_sample;
    logic signed [AW:0]   w_diff;
    logic signed [PW-1:0] w_prod;
    logic signed [SW-1:0] w_sum;

    // old*(1-c) + new*c == old + (new - old)*c, exact in integers
    assign w_sample = {i_ft, {FRAC_BITS{1'b0}}};
    assign w_diff   = $signed({1'b0, w_sample}) - $signed({1'b0, i_avg});
    assign w_prod   = w_diff * COEF;
    assign w_sum    = $signed({1'b0, i_avg, {SH{1'b0}}}) + SW'(w_prod);

    // Sum lies between old and new, so it is never negative and fits AW bits
    assign o_avg = w_sum[AW+SH-1:SH];

endmodule

FILE: rtl/ftqg_tier_ctrl.sv
// ----------------------------------------------------------------------------
// ftqg_tier_ctrl
// Governor state: average, slow/fast counters, cooldown and tier decision.
// ----------------------------------------------------------------------------
module ftqg_tier_ctrl #(
    parameter int FRAC_BITS   = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [ftqg_pkg::TIME_W-1:0] i_ft,
    input  ftqg_pkg::t_cfg              i_cfg,
    output ftqg_pkg::t_result           o_result
);

    localparam int AW   = ftqg_pkg::TIME_W + FRAC_BITS;
    localparam int CMPW = (COUNT_WIDTH > ftqg_pkg::WIN_W) ? COUNT_WIDTH : ftqg_pkg::WIN_W;
    localparam logic [AW-1:0] AVG_RESET = AW'(ftqg_pkg::AVG_START_US) << FRAC_BITS;

    logic                         r_started, n_started;
    ftqg_pkg::t_tier              r_tier,    n_tier;
    logic [AW-1:0]                r_avg,     n_avg;
    logic [COUNT_WIDTH-1:0]       r_slow,    n_slow;
    logic [COUNT_WIDTH-1:0]       r_fast,    n_fast;
    logic [ftqg_pkg::HOLD_W-1:0]  r_hold,    n_hold;

    logic [AW-1:0]                w_avg_upd;
    ftqg_pkg::t_tier              w_base_tier;
    logic [ftqg_pkg::HOLD_W-1:0]  w_base_hold;
    logic [ftqg_pkg::HOLD_W-1:0]  w_hold_dec;
    logic                         w_is_slow;
    logic                         w_is_fast;
    logic                         w_down;
    logic                         w_up;
    logic                         w_changed;
    logic                         w_lowered;

    ftqg_avg_update #(
        .FRAC_BITS (FRAC_BITS)
    ) u_avg (
        .i_avg (r_avg),
        .i_ft  (i_ft),
        .o_avg (w_avg_upd)
    );

    // Values at the first nonzero frame come from the registers
    assign w_base_tier = r_started ? r_tier :
                         ((i_cfg.startup_tier > ftqg_pkg::TIER_LOW) ? ftqg_pkg::TIER_LOW
                                                                    : i_cfg.startup_tier);
    assign w_base_hold = r_started ? r_hold : i_cfg.cooldown;
    assign w_hold_dec  = (w_base_hold != '0) ? w_base_hold - 1'b1 : w_base_hold;

    // Threshold compares on the new average
    assign w_is_slow = w_avg_upd > {i_cfg.degrade_thr, {FRAC_BITS{1'b0}}};
    assign w_is_fast = w_avg_upd < {i_cfg.recover_thr, {FRAC_BITS{1'b0}}};

    // Next state and decision
    always_comb begin
        n_started = r_started;
        n_tier    = r_tier;
        n_avg     = r_avg;
        n_slow    = r_slow;
        n_fast    = r_fast;
        n_hold    = r_hold;
        w_down    = 1'b0;
        w_up      = 1'b0;
        w_changed = 1'b0;
        w_lowered = 1'b0;
        if (i_ft != '0) begin
            n_started = 1'b1;
            n_tier    = w_base_tier;
            n_avg     = w_avg_upd;
            n_hold    = w_hold_dec;
            // saturating run counters
            if (w_is_slow) begin
                n_slow = (&r_slow) ? r_slow : r_slow + 1'b1;
                n_fast = '0;
            end else if (w_is_fast) begin
                n_fast = (&r_fast) ? r_fast : r_fast + 1'b1;
                n_slow = '0;
            end else begin
                n_slow = '0;
                n_fast = '0;
            end
            // decision once cooldown has run out, degrade wins
            if (w_hold_dec == '0) begin
                w_down = CMPW'(n_slow) >= CMPW'(i_cfg.degrade_win);
                w_up   = !w_down && (CMPW'(n_fast) >= CMPW'(i_cfg.recover_win));
                if (w_down && (w_base_tier < ftqg_pkg::TIER_LOW)) begin
                    n_tier    = w_base_tier + 1'b1;
                    w_changed = 1'b1;
                    w_lowered = 1'b1;
                end else if (w_up && (w_base_tier > ftqg_pkg::TIER_HIGH)) begin
                    n_tier    = w_base_tier - 1'b1;
                    w_changed = 1'b1;
                end
                if (w_down || w_up) begin
                    n_slow = '0;
                    n_fast = '0;
                    n_hold = i_cfg.cooldown;
                end
            end
        end
    end

    assign o_result.active_tier      = n_tier;
    assign o_result.tier_changed     = w_changed;
    assign o_result.tier_lowered     = w_lowered;
    assign o_result.smoothed_time_us = n_avg[AW-1:FRAC_BITS];

    // State update once per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_tier    <= ftqg_pkg::TIER_HIGH;
            r_avg     <= AVG_RESET;
            r_slow    <= '0;
            r_fast    <= '0;
            r_hold    <= '0;
        end else if (i_step) begin
            r_started <= n_started;
            r_tier    <= n_tier;
            r_avg     <= n_avg;
            r_slow    <= n_slow;
            r_fast    <= n_fast;
            r_hold    <= n_hold;
        end
    end

endmodule

FILE: rtl/frame_time_quality_governor_unit.sv
// ----------------------------------------------------------------------------
// frame_time_quality_governor_unit
// Top level: input register, governor update, result register.
// ----------------------------------------------------------------------------
// One frame time transaction in, one result transaction out. The block takes
// a new frame time every clock cycle while the result register is free or
// drained. While the frame time sits in the input register, a combinational
// update (one 29x14 multiply for the average, compares and counter logic)
// computes the outcome, which is written to the result register together
// with the governor state when the stage advances. The result register lets
// the next frame time be taken while a result waits. A frame time of zero
// changes nothing and reports the current tier and average. The user is to
// write registers through the configuration channel only while no
// transaction is in flight; the block itself does not enforce this.
module frame_time_quality_governor_unit #(
    parameter int FRAC_BITS   = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ftqg_frame_if.sink    i_frame,
    ftqg_result_if.source o_result,
    ftqg_cfg_if.sink      i_cfg
);

    logic                         r_in_valid;
    logic [ftqg_pkg::TIME_W-1:0]  r_ft;
    logic                         r_out_valid;
    ftqg_pkg::t_result            r_res;

    ftqg_pkg::t_cfg               w_cfg;
    ftqg_pkg::t_result            w_res;
    logic                         w_adv;
    logic                         w_in_acc;

    ftqg_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    ftqg_tier_ctrl #(
        .FRAC_BITS   (FRAC_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_adv),
        .i_ft     (r_ft),
        .i_cfg    (w_cfg),
        .o_result (w_res)
    );

    // Handshake: stage moves when the result register is free or drained
    assign w_adv         = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_frame.ready = !r_in_valid || w_adv;
    assign w_in_acc      = i_frame.valid && i_frame.ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_in_acc || (r_in_valid && !w_adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ft <= i_frame.frame_time_us;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_adv || (r_out_valid && !o_result.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.active_tier      = r_res.active_tier;
    assign o_result.tier_changed     = r_res.tier_changed;
    assign o_result.tier_lowered     = r_res.tier_lowered;
    assign o_result.smoothed_time_us = r_res.smoothed_time_us;

endmodule

FILE: tb/frame_time_quality_governor_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_time_quality_governor_unit_tb
// Self-checking bench for the frame time quality governor. A scoreboard
// class tracks the governor state (average, slow/fast runs, cooldown, tier)
// and predicts one result per accepted frame time. Directed frames cover
// startup, tier limits, extreme thresholds, zero windows and masked or unused
// register writes. Bursts of slow, fast and mixed frame times follow under
// several register settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module frame_time_quality_governor_unit_tb;

    localparam int FRAC          = 8;
    localparam int AVG_W         = ftqg_pkg::TIME_W + FRAC;
    localparam int CNT_W         = 16;
    localparam int AVG_KEEP      = (1 << ftqg_pkg::COEF_SHIFT) - ftqg_pkg::COEF_NEW;
    localparam int TIME_MAX      = (1 << ftqg_pkg::TIME_W) - 1;
    localparam int SETTLE_CYCLES = 4;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT    = 2000;
    localparam int PHASE_FRAMES  = 170;
    localparam int NUM_PHASES    = 6;

    // Indexes past the last register; writes there must be dropped
    localparam logic [ftqg_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [ftqg_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    // ------------------------------------------------------------------------
    // Governor tracker: register copy, state copy and pending results
    // ------------------------------------------------------------------------
    class governor_scoreboard;
        logic [ftqg_pkg::TIME_W-1:0] degrade_thr;
        logic [ftqg_pkg::TIME_W-1:0] recover_thr;
        logic [ftqg_pkg::WIN_W-1:0]  degrade_win;
        logic [ftqg_pkg::WIN_W-1:0]  recover_win;
        logic [ftqg_pkg::HOLD_W-1:0] cooldown;
        ftqg_pkg::t_tier             startup_tier;

        bit                          started;
        ftqg_pkg::t_tier             tier;
        logic [AVG_W-1:0]            avg;
        logic [CNT_W-1:0]            slow_run;
        logic [CNT_W-1:0]            fast_run;
        logic [ftqg_pkg::HOLD_W-1:0] hold;

        ftqg_pkg::t_result           due_q[$];
        int                          errors;
        int                          frames;
        int                          results;
        int                          lowered_cnt;
        int                          raised_cnt;

        function new();
            degrade_thr  = ftqg_pkg::RST_DEGRADE_THR;
            recover_thr  = ftqg_pkg::RST_RECOVER_THR;
            degrade_win  = ftqg_pkg::RST_DEGRADE_WIN;
            recover_win  = ftqg_pkg::RST_RECOVER_WIN;
            cooldown     = ftqg_pkg::RST_COOLDOWN;
            startup_tier = ftqg_pkg::RST_STARTUP_TIER;
            started      = 1'b0;
            tier         = ftqg_pkg::TIER_HIGH;
            avg          = AVG_W'(ftqg_pkg::AVG_START_US) << FRAC;
            slow_run     = '0;
            fast_run     = '0;
            hold         = '0;
        endfunction

        function void write_reg(logic [ftqg_pkg::CFG_IDX_W-1:0] idx,
                                logic [ftqg_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                ftqg_pkg::REG_DEGRADE_THR:  degrade_thr  = data[ftqg_pkg::TIME_W-1:0];
                ftqg_pkg::REG_RECOVER_THR:  recover_thr  = data[ftqg_pkg::TIME_W-1:0];
                ftqg_pkg::REG_DEGRADE_WIN:  degrade_win  = data[ftqg_pkg::WIN_W-1:0];
                ftqg_pkg::REG_RECOVER_WIN:  recover_win  = data[ftqg_pkg::WIN_W-1:0];
                ftqg_pkg::REG_COOLDOWN:     cooldown     = data[ftqg_pkg::HOLD_W-1:0];
                ftqg_pkg::REG_STARTUP_TIER: startup_tier = data[ftqg_pkg::TIER_W-1:0];
                default: ;
            endcase
        endfunction

        // One accepted frame time: advance the state, queue the result
        function void note_frame(logic [ftqg_pkg::TIME_W-1:0] ft);
            ftqg_pkg::t_result r;
            logic [63:0]       mix;
            logic [AVG_W-1:0]  slow_lim;
            logic [AVG_W-1:0]  fast_lim;
            bit                down;
            bit                up;
            r.tier_changed = 1'b0;
            r.tier_lowered = 1'b0;
            frames++;
            if (ft != '0) begin
                if (!started) begin
                    started  = 1'b1;
                    tier     = (startup_tier > ftqg_pkg::TIER_LOW) ? ftqg_pkg::TIER_LOW
                                                                   : startup_tier;
                    avg      = AVG_W'(ftqg_pkg::AVG_START_US) << FRAC;
                    slow_run = '0;
                    fast_run = '0;
                    hold     = cooldown;
                end
                // 0.9 old + 0.1 new in Q0.16, truncated
                mix = 64'(avg) * 64'(AVG_KEEP) + (64'(ft) << FRAC) * 64'(ftqg_pkg::COEF_NEW);
                avg = AVG_W'(mix >> ftqg_pkg::COEF_SHIFT);
                if (hold != '0)
                    hold = hold - 1'b1;
                slow_lim = AVG_W'(degrade_thr) << FRAC;
                fast_lim = AVG_W'(recover_thr) << FRAC;
                if (avg > slow_lim) begin
                    if (slow_run != '1)
                        slow_run = slow_run + 1'b1;
                    fast_run = '0;
                end else if (avg < fast_lim) begin
                    if (fast_run != '1)
                        fast_run = fast_run + 1'b1;
                    slow_run = '0;
                end else begin
                    slow_run = '0;
                    fast_run = '0;
                end
                // Tier decision once the cooldown has run out
                if (hold == '0) begin
                    down = (slow_run >= degrade_win);
                    up   = !down && (fast_run >= recover_win);
                    if (down && tier < ftqg_pkg::TIER_LOW) begin
                        tier = tier + 1'b1;
                        r.tier_changed = 1'b1;
                        r.tier_lowered = 1'b1;
                        lowered_cnt++;
                    end else if (up && tier > ftqg_pkg::TIER_HIGH) begin
                        tier = tier - 1'b1;
                        r.tier_changed = 1'b1;
                        raised_cnt++;
                    end
                    if (down || up) begin
                        slow_run = '0;
                        fast_run = '0;
                        hold     = cooldown;
                    end
                end
            end
            r.active_tier      = tier;
            r.smoothed_time_us = avg[FRAC +: ftqg_pkg::TIME_W];
            due_q.insert(due_q.size(), r);
        endfunction

        function void check_field(string name, logic [ftqg_pkg::TIME_W-1:0] want,
                                  logic [ftqg_pkg::TIME_W-1:0] seen);
            if (seen !== want) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0d, got %0d",
                         $time, name, want, seen);
            end
        endfunction

        function void check_result(ftqg_pkg::t_result got);
            ftqg_pkg::t_result want;
            if (due_q.size() == 0) begin
                errors++;
                $display("%0t ns: result with no frame pending (tier %0d, avg %0d us)",
                         $time, got.active_tier, got.smoothed_time_us);
                return;
            end
            want = due_q.pop_front();
            results++;
            check_field("active_tier", ftqg_pkg::TIME_W'(want.active_tier),
                        ftqg_pkg::TIME_W'(got.active_tier));
            check_field("tier_changed", ftqg_pkg::TIME_W'(want.tier_changed),
                        ftqg_pkg::TIME_W'(got.tier_changed));
            check_field("tier_lowered", ftqg_pkg::TIME_W'(want.tier_lowered),
                        ftqg_pkg::TIME_W'(got.tier_lowered));
            check_field("smoothed_time_us", want.smoothed_time_us, got.smoothed_time_us);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #10 i_clk = ~i_clk;

    ftqg_frame_if  frame_ch ();
    ftqg_result_if result_ch ();
    ftqg_cfg_if    cfg_ch ();

    frame_time_quality_governor_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    governor_scoreboard sb = new();

    bit full_speed  = 1'b0;
    bit rx_hold_req = 1'b0;
    int cur_deg;
    int cur_rec;
    int settings    = 0;
    int idle_cycles = 0;

    // ------------------------------------------------------------------------
    // Monitor: every transaction on all three channels at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        ftqg_pkg::t_result got;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_reg(cfg_ch.index, cfg_ch.data);
            if (frame_ch.valid && frame_ch.ready)
                sb.note_frame(frame_ch.frame_time_us);
            if (result_ch.valid && result_ch.ready) begin
                got.active_tier      = result_ch.active_tier;
                got.tier_changed     = result_ch.tier_changed;
                got.tier_lowered     = result_ch.tier_lowered;
                got.smoothed_time_us = result_ch.smoothed_time_us;
                sb.check_result(got);
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: watchdog, no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result sink: random ready runs, optional long hold-off
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int pick;
        int run;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                result_ch.ready = 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end else if (full_speed) begin
                result_ch.ready = 1'b1;
            end else begin
                pick = $urandom_range(99, 0);
                if (pick < 55) begin
                    result_ch.ready = 1'b1;
                    run = $urandom_range(24, 1);
                end else begin
                    result_ch.ready = 1'b0;
                    if (pick < 85)
                        run = $urandom_range(3, 1);
                    else if (pick < 97)
                        run = $urandom_range(12, 4);
                    else
                        run = $urandom_range(80, 30);
                end
                repeat (run - 1) @(negedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_frame(input logic [ftqg_pkg::TIME_W-1:0] ft);
        int pick;
        int gap;
        pick = $urandom_range(99, 0);
        if (full_speed || pick < 60)
            gap = 0;
        else if (pick < 88)
            gap = $urandom_range(3, 1);
        else if (pick < 98)
            gap = $urandom_range(12, 4);
        else
            gap = $urandom_range(50, 20);
        @(negedge i_clk);
        if (gap > 0) begin
            frame_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        frame_ch.valid         = 1'b1;
        frame_ch.frame_time_us = ft;
        do @(posedge i_clk); while (!frame_ch.ready);
    endtask

    task automatic write_cfg(input logic [ftqg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ftqg_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Stop offering frames and let every pending result come out
    task automatic drain();
        @(negedge i_clk);
        frame_ch.valid = 1'b0;
        while (sb.due_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(input int deg_thr, input int rec_thr, input int deg_win,
                                input int rec_win, input int hold, input int start_tier);
        drain();
        cur_deg = deg_thr;
        cur_rec = rec_thr;
        settings++;
        write_cfg(ftqg_pkg::REG_DEGRADE_THR, ftqg_pkg::CFG_DATA_W'(deg_thr));
        write_cfg(ftqg_pkg::REG_RECOVER_THR, ftqg_pkg::CFG_DATA_W'(rec_thr));
        write_cfg(ftqg_pkg::REG_DEGRADE_WIN, ftqg_pkg::CFG_DATA_W'(deg_win));
        write_cfg(ftqg_pkg::REG_RECOVER_WIN, ftqg_pkg::CFG_DATA_W'(rec_win));
        write_cfg(ftqg_pkg::REG_COOLDOWN, ftqg_pkg::CFG_DATA_W'(hold));
        write_cfg(ftqg_pkg::REG_STARTUP_TIER, ftqg_pkg::CFG_DATA_W'(start_tier));
    endtask

    // Bursts of slow, fast, borderline, zero and fully random frame times
    task automatic run_traffic(input int count, input bit with_hold_off);
        int n;
        int i;
        int kind;
        int len;
        int lo;
        int hi;
        logic [ftqg_pkg::TIME_W-1:0] ft;
        n = 0;
        while (n < count) begin
            kind = $urandom_range(99, 0);
            len  = (kind >= 82 && kind < 90) ? $urandom_range(3, 1) : $urandom_range(40, 4);
            for (i = 0; i < len && n < count; i++) begin
                if (kind < 35) begin
                    lo = cur_deg + 1;
                    hi = cur_deg * 3 + 2000;
                end else if (kind < 70) begin
                    lo = 1;
                    hi = cur_rec;
                end else if (kind < 82) begin
                    lo = cur_rec;
                    hi = cur_deg;
                end else begin
                    lo = 0;
                    hi = 0;
                end
                if (hi > TIME_MAX)
                    hi = TIME_MAX;
                if (lo > hi)
                    lo = hi;
                ft = (kind >= 90) ? ftqg_pkg::TIME_W'($urandom)
                                  : ftqg_pkg::TIME_W'($urandom_range(hi, lo));
                if (with_hold_off && n == count / 3)
                    rx_hold_req = 1'b1;
                send_frame(ft);
                if (ft != '0)
                    n++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int p;
        int deg;
        frame_ch.valid         = 1'b0;
        frame_ch.frame_time_us = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = '0;
        cfg_ch.data            = '0;
        cur_deg                = ftqg_pkg::RST_DEGRADE_THR;
        cur_rec                = ftqg_pkg::RST_RECOVER_THR;

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Startup: zero before start, startup tier 3 saturates to low,
        // slow frames at the tier limit
        program_regs(ftqg_pkg::RST_DEGRADE_THR, ftqg_pkg::RST_RECOVER_THR, 2, 1, 2, 3);
        send_frame(20'd0);
        send_frame(20'hFFFFF);
        send_frame(20'hFFFFF);
        send_frame(20'hFFFFF);
        send_frame(20'hFFFFF);
        send_frame(20'd0);

        // Thresholds at max: every frame fast, tier climbs to high and sticks
        program_regs(TIME_MAX, TIME_MAX, 2, 1, 0, 0);
        send_frame(20'd1);
        send_frame(20'd1);
        send_frame(20'h55555);
        send_frame(20'hAAAAA);
        send_frame(20'h80000);
        send_frame(20'd0);

        // Zero thresholds and zero windows: a decision every frame, degrade wins
        program_regs(0, 0, 0, 0, 0, 1);
        send_frame(20'd1);
        send_frame(20'h7FFFF);
        send_frame(20'hFFFFF);
        send_frame(20'd1);

        // Unused indexes are dropped, oversized window data is masked
        drain();
        write_cfg(REG_SPARE_6, '1);
        write_cfg(REG_SPARE_7, 20'h12345);
        write_cfg(ftqg_pkg::REG_DEGRADE_THR, 20'hFFFFF);
        write_cfg(ftqg_pkg::REG_RECOVER_THR, 20'hFFFFF);
        write_cfg(ftqg_pkg::REG_RECOVER_WIN, 20'hF0002);
        cur_deg = TIME_MAX;
        cur_rec = TIME_MAX;
        send_frame(20'd1);
        send_frame(20'd1);
        send_frame(20'd1);

        // Random phases under different settings
        for (p = 0; p < NUM_PHASES; p++) begin
            deg = $urandom_range(40000, 12000);
            case (p)
                0: program_regs(ftqg_pkg::RST_DEGRADE_THR, ftqg_pkg::RST_RECOVER_THR,
                                $urandom_range(8, 1), $urandom_range(8, 1),
                                $urandom_range(10, 0), $urandom_range(3, 0));
                1: program_regs(deg, $urandom_range(deg, 5000), $urandom_range(12, 1),
                                $urandom_range(12, 1), $urandom_range(15, 0),
                                $urandom_range(3, 0));
                2: program_regs(deg, $urandom_range(deg, 5000), 16'hFFFF, 16'hFFFF,
                                16'hFFFF, $urandom_range(3, 0));
                3: program_regs(deg, $urandom_range(deg, 5000), 1, 1, 0, 0);
                4: program_regs(deg, $urandom_range(deg, 5000), $urandom_range(30, 1),
                                $urandom_range(30, 1), $urandom_range(40, 0), 2);
                default: begin
                    deg = $urandom_range(TIME_MAX, 0);
                    program_regs(deg, $urandom_range(TIME_MAX, 0), $urandom_range(6, 1),
                                 $urandom_range(6, 1), $urandom_range(6, 0), 1);
                end
            endcase
            full_speed = (p == 3);
            run_traffic(PHASE_FRAMES, p == 1);
            full_speed = 1'b0;
        end

        drain();
        $display("Covered %0d frame transactions, %0d results checked, %0d register settings",
                 sb.frames, sb.results, settings);
        $display("Tier moves seen: %0d down, %0d up; %0d mismatches",
                 sb.lowered_cnt, sb.raised_cnt, sb.errors);
        if (sb.errors == 0 && sb.due_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: files.f
rtl/ftqg_pkg.sv
rtl/ftqg_if.sv
rtl/ftqg_cfg_regs.sv
rtl/ftqg_avg_update.sv
rtl/ftqg_tier_ctrl.sv
rtl/frame_time_quality_governor_unit.sv
tb/frame_time_quality_governor_unit_tb.sv
